// ----- rtl/tgr_pkg.sv -----
// shared types and constants for the text glyph renderer
`timescale 1ns / 1ps
`default_nettype none
package tgr_pkg;

  typedef logic [15:0] rgb565_t;

  // operation codes
  localparam logic [1:0] OP_LOAD_GLYPH = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_DRAW_CHAR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PANEL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_PANEL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FONT_WBYTES  = 3'd2;
  localparam logic [2:0] REG_FONT_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_TEXT_COLOR   = 3'd4;
  localparam logic [2:0] REG_BACK_COLOR   = 3'd5;
  localparam logic [2:0] REG_WRAP_CLEARS  = 3'd6;

  // configuration reset values
  localparam logic [10:0] RST_PANEL_WIDTH  = 11'd480;
  localparam logic [10:0] RST_PANEL_HEIGHT = 11'd272;
  localparam logic [1:0]  RST_FONT_WBYTES  = 2'd1;
  localparam logic [4:0]  RST_FONT_HEIGHT  = 5'd16;
  localparam rgb565_t     RST_TEXT_COLOR   = 16'hFFFF;
  localparam rgb565_t     RST_BACK_COLOR   = 16'h0000;
  localparam logic        RST_WRAP_CLEARS  = 1'b1;

  // character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;

  // cursor limits
  localparam logic [10:0] CURSOR_Y_MAX = 11'd2047;
  localparam logic [9:0]  CURSOR_X_MAX = 10'd1023;

  // glyph bytes per glyph slot in the store addressing
  localparam int SLOT_BYTES = 32;

endpackage
`default_nettype wire

// ----- rtl/tgr_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/text_glyph_renderer_core.sv -----
// text console character generator: font store, cursor and glyph expansion
//
// Input channel (in_valid / in_stall) takes one beat per operation: load a
// font store byte, set the cursor, or draw a character. Loads, cursor sets,
// newlines and codes without a glyph finish in the accepting cycle and emit
// nothing. A printable character stalls the input while it is drawn: four
// setup steps (right-edge wrap, bottom wrap, row multiply, first store
// read) and then one result beat per cycle while the result side does not
// stall, 2 * font_width_bytes * font_height beats in all (32 for an 8x16
// font). The single font store read port delivers one glyph byte per two
// result beats. Result channel (out_valid / out_stall) carries four RGB565
// pixels, their linear framebuffer index, a clear flag (if enabled) on the
// first beat after a wrap to the top and a last flag on the final beat of
// the character. A stall on the result side holds the output register and
// pauses the sequencer. Configuration writes (cfg_we) take effect at once;
// they must be made while idle by the user; the block does not enforce it.
// Reset (synchronous, rst_n low) restores the configuration defaults, puts
// the cursor at the top left and drops out_valid; the font store is not
// cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module text_glyph_renderer_core #(
  parameter int GLYPH_COUNT     = 96,
  parameter int MAX_GLYPH_BYTES = 32,
  parameter int MAX_PANEL_WIDTH = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_op,
  input  wire logic [11:0]     in_glyph_addr,
  input  wire logic [7:0]      in_glyph_byte,
  input  wire logic [9:0]      in_x_pos,
  input  wire logic [9:0]      in_y_pos,
  input  wire logic [7:0]      in_char_code,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [19:0]          out_pixel_index,
  output tgr_pkg::rgb565_t     out_pixel_a,
  output tgr_pkg::rgb565_t     out_pixel_b,
  output tgr_pkg::rgb565_t     out_pixel_c,
  output tgr_pkg::rgb565_t     out_pixel_d,
  output logic                 out_clear_first,
  output logic                 out_last
);
  import tgr_pkg::*;

  localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_BYTES;
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int RA_W        = $clog2(GLYPH_COUNT * SLOT_BYTES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRAP   = 3'd1;
  localparam logic [2:0] S_BOTTOM = 3'd2;
  localparam logic [2:0] S_LINE   = 3'd3;
  localparam logic [2:0] S_START  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  // configuration
  logic [10:0] panel_width_r, panel_height_r;
  logic [1:0]  font_wbytes_r;
  logic [4:0]  font_height_r;
  rgb565_t     text_color_r, back_color_r;
  logic        wrap_clears_r;

  // cursor and sequencer
  logic [9:0]      cursor_x_r;
  logic [10:0]     cursor_y_r;
  logic [2:0]      state_r;
  logic [7:0]      gidx_r;
  logic [RA_W-1:0] base_r, addr_r;
  logic [19:0]     line_r, row_base_r, idx_r;
  logic [9:0]      x_r;
  logic [3:0]      row_r;
  logic            col_r, half_r, clr_r, rd_oob_r;

  // output register
  logic        out_valid_r;
  logic [19:0] out_index_r;
  rgb565_t     out_a_r, out_b_r, out_c_r, out_d_r;
  logic        out_clear_r, out_last_r;

  // derived font and panel sizes
  logic        wide;
  logic [4:0]  fw, fh;
  logic [5:0]  bpg;
  logic [10:0] pw;
  logic [11:0] x_sum, y_sum, cx_sum;
  logic [10:0] y_sat;
  logic        glyph_ok, last_beat, slot_free, in_fire, store_wr;
  logic [7:0]  rd_byte, code_ofs;
  logic [SA_W-1:0] wr_addr;
  logic [7:0]  rdata;

  assign wide  = font_wbytes_r[1];
  assign fw    = wide ? 5'd16 : 5'd8;
  assign fh    = (font_height_r == 5'd0) ? 5'd1 :
                 ((font_height_r > 5'd16) ? 5'd16 : font_height_r);
  assign bpg   = wide ? {fh, 1'b0} : {1'b0, fh};
  assign pw    = (32'(panel_width_r) > MAX_PANEL_WIDTH) ? 11'(MAX_PANEL_WIDTH)
                                                          : panel_width_r;
  assign x_sum  = {2'b00, cursor_x_r} + {7'd0, fw};
  assign y_sum  = {1'b0, cursor_y_r} + {7'd0, fh};
  assign y_sat  = y_sum[11] ? CURSOR_Y_MAX : y_sum[10:0];
  assign cx_sum = {2'b00, cursor_x_r} + {7'd0, fw};

  assign code_ofs = in_char_code - CHAR_FIRST;
  assign glyph_ok = (in_char_code >= CHAR_FIRST) && (32'(code_ofs) < GLYPH_COUNT);

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign last_beat = half_r && (col_r == wide) && (row_r == 4'(fh - 5'd1));
  assign rd_byte   = rd_oob_r ? 8'd0 : rdata;

  assign store_wr = in_fire && (in_op == OP_LOAD_GLYPH) &&
                    (32'(in_glyph_addr) < STORE_DEPTH);
  assign wr_addr  = SA_W'(in_glyph_addr);

  logic            rd_en;
  logic [RA_W-1:0] rd_addr;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_r;
    if (state_r == S_START) begin
      rd_en   = 1'b1;
      rd_addr = base_r;
    end else if (state_r == S_EMIT && slot_free && half_r && !last_beat) begin
      rd_en   = 1'b1;
    end
  end

  tgr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_wr),
    .waddr(wr_addr),
    .wdata(in_glyph_byte),
    .re   (rd_en),
    .raddr(SA_W'(rd_addr)),
    .rdata(rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= RST_PANEL_WIDTH;
      panel_height_r <= RST_PANEL_HEIGHT;
      font_wbytes_r  <= RST_FONT_WBYTES;
      font_height_r  <= RST_FONT_HEIGHT;
      text_color_r   <= RST_TEXT_COLOR;
      back_color_r   <= RST_BACK_COLOR;
      wrap_clears_r  <= RST_WRAP_CLEARS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PANEL_WIDTH:  panel_width_r  <= cfg_wdata[10:0];
        REG_PANEL_HEIGHT: panel_height_r <= cfg_wdata[10:0];
        REG_FONT_WBYTES:  font_wbytes_r  <= cfg_wdata[1:0];
        REG_FONT_HEIGHT:  font_height_r  <= cfg_wdata[4:0];
        REG_TEXT_COLOR:   text_color_r   <= cfg_wdata;
        REG_BACK_COLOR:   back_color_r   <= cfg_wdata;
        REG_WRAP_CLEARS:  wrap_clears_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      clr_r      <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_op)
              OP_SET_CURSOR: begin
                cursor_x_r <= in_x_pos;
                cursor_y_r <= {1'b0, in_y_pos};
              end
              OP_DRAW_CHAR: begin
                gidx_r <= code_ofs;
                if (in_char_code == CHAR_NEWLINE) begin
                  cursor_x_r <= '0;
                  cursor_y_r <= y_sat;
                end else if (glyph_ok) begin
                  state_r <= S_WRAP;
                end
              end
              default: ;
            endcase
          end
        end
        S_WRAP: begin
          clr_r  <= 1'b0;
          base_r <= RA_W'(gidx_r) * RA_W'(bpg);
          if (x_sum > {1'b0, pw}) begin
            cursor_x_r <= '0;
            cursor_y_r <= y_sat;
          end
          state_r <= S_BOTTOM;
        end
        S_BOTTOM: begin
          if (y_sum > {1'b0, panel_height_r}) begin
            cursor_x_r <= '0;
            cursor_y_r <= '0;
            clr_r      <= wrap_clears_r;
          end
          state_r <= S_LINE;
        end
        S_LINE: begin
          line_r  <= 20'(cursor_y_r) * 20'(pw);
          x_r     <= cursor_x_r;
          state_r <= S_START;
        end
        S_START: begin
          row_base_r <= line_r;
          idx_r      <= line_r + 20'(x_r);
          addr_r     <= base_r + RA_W'(1);
          rd_oob_r   <= (32'(base_r) >= STORE_DEPTH);
          row_r      <= '0;
          col_r      <= 1'b0;
          half_r     <= 1'b0;
          cursor_x_r <= cx_sum[11:10] != 2'b00 ? CURSOR_X_MAX : cx_sum[9:0];
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            clr_r <= 1'b0;
            if (!half_r) begin
              half_r <= 1'b1;
              idx_r  <= idx_r + 20'd4;
            end else begin
              half_r <= 1'b0;
              if (!last_beat) begin
                addr_r   <= addr_r + RA_W'(1);
                rd_oob_r <= (32'(addr_r) >= STORE_DEPTH);
              end
              if (wide && !col_r) begin
                col_r <= 1'b1;
                idx_r <= idx_r + 20'd4;
              end else begin
                col_r      <= 1'b0;
                row_r      <= row_r + 4'd1;
                row_base_r <= row_base_r + 20'(pw);
                idx_r      <= row_base_r + 20'(pw) + 20'(x_r);
              end
              if (last_beat) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && slot_free) begin
      out_index_r <= idx_r;
      out_a_r     <= (half_r ? rd_byte[3] : rd_byte[7]) ? text_color_r : back_color_r;
      out_b_r     <= (half_r ? rd_byte[2] : rd_byte[6]) ? text_color_r : back_color_r;
      out_c_r     <= (half_r ? rd_byte[1] : rd_byte[5]) ? text_color_r : back_color_r;
      out_d_r     <= (half_r ? rd_byte[0] : rd_byte[4]) ? text_color_r : back_color_r;
      out_clear_r <= clr_r;
      out_last_r  <= last_beat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_pixel_a     = out_a_r;
  assign out_pixel_b     = out_b_r;
  assign out_pixel_c     = out_c_r;
  assign out_pixel_d     = out_d_r;
  assign out_clear_first = out_clear_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ----- tb/sv/tgr_render_checker.sv -----
// pixel beat checker for the text glyph renderer: tracks font, cursor and registers
`timescale 1ns / 1ps
module tgr_render_checker #(
  parameter int GLYPH_COUNT     = 96,
  parameter int MAX_GLYPH_BYTES = 32,
  parameter int MAX_PANEL_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [11:0]      in_glyph_addr,
  input  logic [7:0]       in_glyph_byte,
  input  logic [9:0]       in_x_pos,
  input  logic [9:0]       in_y_pos,
  input  logic [7:0]       in_char_code,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [19:0]      out_pixel_index,
  input  tgr_pkg::rgb565_t out_pixel_a,
  input  tgr_pkg::rgb565_t out_pixel_b,
  input  tgr_pkg::rgb565_t out_pixel_c,
  input  tgr_pkg::rgb565_t out_pixel_d,
  input  logic             out_clear_first,
  input  logic             out_last,
  output int               fail_count,
  output int               outstanding
);
  import tgr_pkg::*;

  localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_BYTES;

  typedef struct packed {
    logic [19:0] pixel_index;
    rgb565_t     pixel_a;
    rgb565_t     pixel_b;
    rgb565_t     pixel_c;
    rgb565_t     pixel_d;
    logic        clear_first;
    logic        last;
  } pixel_beat_t;

  logic [7:0]  font_mem [STORE_DEPTH];
  logic [9:0]  cur_x;
  logic [10:0] cur_y;
  logic [10:0] reg_pw;
  logic [10:0] reg_ph;
  logic [1:0]  reg_fwb;
  logic [4:0]  reg_fh;
  rgb565_t     reg_text;
  rgb565_t     reg_back;
  logic        reg_wrap;

  pixel_beat_t expected_pixels [$];
  int          errors = 0;

  function automatic void render_op(input logic [1:0] op, input logic [11:0] addr,
                                    input logic [7:0] data, input logic [9:0] xpos,
                                    input logic [9:0] ypos, input logic [7:0] code);
    int          fwb;
    int          fh;
    int          fw;
    int          pw;
    int          nxt;
    int          x;
    int          y;
    int          base;
    int          lin;
    logic [7:0]  bits;
    logic        clr;
    pixel_beat_t beat;
    fwb = (reg_fwb == 2'd0) ? 1 : ((reg_fwb > 2'd2) ? 2 : int'(reg_fwb));
    fh  = (reg_fh == 5'd0) ? 1 : ((reg_fh > 5'd16) ? 16 : int'(reg_fh));
    fw  = 8 * fwb;
    pw  = (reg_pw > MAX_PANEL_WIDTH) ? MAX_PANEL_WIDTH : int'(reg_pw);
    clr = 1'b0;
    if (op == OP_LOAD_GLYPH) begin
      if (addr < STORE_DEPTH) font_mem[addr] = data;
      return;
    end
    if (op == OP_SET_CURSOR) begin
      cur_x = xpos;
      cur_y = {1'b0, ypos};
      return;
    end
    if (op != OP_DRAW_CHAR) return;
    if (code == CHAR_NEWLINE) begin
      nxt = int'(cur_y) + fh;
      cur_x = '0;
      cur_y = (nxt > CURSOR_Y_MAX) ? CURSOR_Y_MAX : nxt[10:0];
      return;
    end
    if (code < CHAR_FIRST || int'(code) - int'(CHAR_FIRST) >= GLYPH_COUNT) return;

    // right edge, then bottom edge
    if (int'(cur_x) + fw > pw) begin
      nxt = int'(cur_y) + fh;
      cur_x = '0;
      cur_y = (nxt > CURSOR_Y_MAX) ? CURSOR_Y_MAX : nxt[10:0];
    end
    if (int'(cur_y) + fh > int'(reg_ph)) begin
      cur_x = '0;
      cur_y = '0;
      clr = reg_wrap;
    end
    x = int'(cur_x);
    y = int'(cur_y);
    base = (int'(code) - int'(CHAR_FIRST)) * fwb * fh;

    for (int row = 0; row < fh; row++) begin
      for (int col = 0; col < fwb; col++) begin
        bits = font_mem[base + row * fwb + col];
        for (int half = 0; half < 2; half++) begin
          lin = (y + row) * pw + x + col * 8 + half * 4;
          beat.pixel_index = lin[19:0];
          beat.pixel_a = bits[7 - 4 * half] ? reg_text : reg_back;
          beat.pixel_b = bits[6 - 4 * half] ? reg_text : reg_back;
          beat.pixel_c = bits[5 - 4 * half] ? reg_text : reg_back;
          beat.pixel_d = bits[4 - 4 * half] ? reg_text : reg_back;
          beat.clear_first = clr && row == 0 && col == 0 && half == 0;
          beat.last = row == fh - 1 && col == fwb - 1 && half == 1;
          expected_pixels.push_back(beat);
        end
      end
    end

    nxt = int'(cur_x) + fw;
    cur_x = (nxt > CURSOR_X_MAX) ? CURSOR_X_MAX : nxt[9:0];
  endfunction

  function automatic void check_field(input string name, input logic [19:0] want,
                                      input logic [19:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst_n) begin
      cur_x    = '0;
      cur_y    = '0;
      reg_pw   = RST_PANEL_WIDTH;
      reg_ph   = RST_PANEL_HEIGHT;
      reg_fwb  = RST_FONT_WBYTES;
      reg_fh   = RST_FONT_HEIGHT;
      reg_text = RST_TEXT_COLOR;
      reg_back = RST_BACK_COLOR;
      reg_wrap = RST_WRAP_CLEARS;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PANEL_WIDTH:  reg_pw   = cfg_wdata[10:0];
          REG_PANEL_HEIGHT: reg_ph   = cfg_wdata[10:0];
          REG_FONT_WBYTES:  reg_fwb  = cfg_wdata[1:0];
          REG_FONT_HEIGHT:  reg_fh   = cfg_wdata[4:0];
          REG_TEXT_COLOR:   reg_text = cfg_wdata;
          REG_BACK_COLOR:   reg_back = cfg_wdata;
          REG_WRAP_CLEARS:  reg_wrap = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        render_op(in_op, in_glyph_addr, in_glyph_byte, in_x_pos, in_y_pos, in_char_code);
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel beat with nothing expected: pixel_index %0h", out_pixel_index);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_index", want.pixel_index, out_pixel_index);
          check_field("pixel_a", want.pixel_a, out_pixel_a);
          check_field("pixel_b", want.pixel_b, out_pixel_b);
          check_field("pixel_c", want.pixel_c, out_pixel_c);
          check_field("pixel_d", want.pixel_d, out_pixel_d);
          check_field("clear_first", want.clear_first, out_clear_first);
          check_field("last", want.last, out_last);
        end
      end
    end
    fail_count  <= errors;
    outstanding <= expected_pixels.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// top of the text glyph renderer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import tgr_pkg::*;

  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         STORE_DEPTH = 96 * 32;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_index     = REG_PANEL_WIDTH;
  logic [15:0] cfg_wdata     = '0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op         = OP_LOAD_GLYPH;
  logic [11:0] in_glyph_addr = '0;
  logic [7:0]  in_glyph_byte = '0;
  logic [9:0]  in_x_pos      = '0;
  logic [9:0]  in_y_pos      = '0;
  logic [7:0]  in_char_code  = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [19:0] out_pixel_index;
  rgb565_t     out_pixel_a;
  rgb565_t     out_pixel_b;
  rgb565_t     out_pixel_c;
  rgb565_t     out_pixel_d;
  logic        out_clear_first;
  logic        out_last;

  int fail_count;
  int outstanding;
  int cycles     = 0;
  int burst_left = 0;
  int beats_sent = 0;
  int fav [4];
  bit loaded [STORE_DEPTH];

  logic [10:0] sh_pw  = RST_PANEL_WIDTH;
  logic [10:0] sh_ph  = RST_PANEL_HEIGHT;
  logic [1:0]  sh_fwb = RST_FONT_WBYTES;
  logic [4:0]  sh_fh  = RST_FONT_HEIGHT;

  int         stall_mode = 0;
  int         stall_left = 0;
  int         stall_tick = 0;
  logic [7:0] stall_mask = '0;

  text_glyph_renderer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_glyph_addr   (in_glyph_addr),
    .in_glyph_byte   (in_glyph_byte),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_pixel_a     (out_pixel_a),
    .out_pixel_b     (out_pixel_b),
    .out_pixel_c     (out_pixel_c),
    .out_pixel_d     (out_pixel_d),
    .out_clear_first (out_clear_first),
    .out_last        (out_last)
  );

  tgr_render_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_glyph_addr   (in_glyph_addr),
    .in_glyph_byte   (in_glyph_byte),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_pixel_a     (out_pixel_a),
    .out_pixel_b     (out_pixel_b),
    .out_pixel_c     (out_pixel_c),
    .out_pixel_d     (out_pixel_d),
    .out_clear_first (out_clear_first),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern: free, random, masked or heavy stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mask = 8'($urandom) & 8'hFE;
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= stall_mask[stall_tick % 8];
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic int font_wbytes();
    return (sh_fwb == 2'd0) ? 1 : ((sh_fwb > 2'd2) ? 2 : int'(sh_fwb));
  endfunction

  function automatic int font_rows();
    return (sh_fh == 5'd0) ? 1 : ((sh_fh > 5'd16) ? 16 : int'(sh_fh));
  endfunction

  function automatic bit glyph_ready(input int code);
    int n;
    int base;
    n = font_wbytes() * font_rows();
    base = (code - int'(CHAR_FIRST)) * n;
    for (int i = 0; i < n; i++) if (!loaded[base + i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_beat(input logic [1:0] op, input int arg0, input int arg1);
    int gap;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_glyph_addr <= (op == OP_LOAD_GLYPH) ? 12'(arg0) : 12'($urandom);
    in_glyph_byte <= (op == OP_LOAD_GLYPH) ? 8'(arg1) : 8'($urandom);
    in_x_pos      <= (op == OP_SET_CURSOR) ? 10'(arg0) : 10'($urandom);
    in_y_pos      <= (op == OP_SET_CURSOR) ? 10'(arg1) : 10'($urandom);
    in_char_code  <= (op == OP_DRAW_CHAR) ? 8'(arg0) : 8'($urandom);
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED) beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  task automatic store_byte(input int addr, input int data);
    send_beat(OP_LOAD_GLYPH, addr, data);
    if (addr < STORE_DEPTH) loaded[addr] = 1'b1;
  endtask

  task automatic load_glyph(input int code);
    int n;
    int base;
    n = font_wbytes() * font_rows();
    base = (code - int'(CHAR_FIRST)) * n;
    for (int i = 0; i < n; i++) store_byte(base + i, $urandom_range(0, 255));
  endtask

  task automatic put_reg(input logic [2:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 16'(data);
    @(posedge clk);
  endtask

  // drain everything in flight, then rewrite all registers
  task automatic write_regs(input int pw, input int ph, input int fwb, input int fh,
                            input int text, input int back, input int wrap);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    put_reg(REG_PANEL_WIDTH, pw);
    put_reg(REG_PANEL_HEIGHT, ph);
    put_reg(REG_FONT_WBYTES, fwb);
    put_reg(REG_FONT_HEIGHT, fh);
    put_reg(REG_TEXT_COLOR, text);
    put_reg(REG_BACK_COLOR, back);
    put_reg(REG_WRAP_CLEARS, wrap);
    cfg_we <= 1'b0;
    sh_pw  = 11'(pw);
    sh_ph  = 11'(ph);
    sh_fwb = 2'(fwb);
    sh_fh  = 5'(fh);
  endtask

  task automatic random_traffic(input int budget);
    int start;
    int pick;
    int code;
    int x;
    int y;
    int addr;
    int epw;
    start = beats_sent;
    for (int i = 0; i < 4; i++) fav[i] = $urandom_range(int'(CHAR_FIRST), 127);
    while (beats_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      epw = (sh_pw > 11'd1024) ? 1024 : int'(sh_pw);
      if (pick < 45) begin
        code = ($urandom_range(0, 2) != 0) ? fav[$urandom_range(0, 3)]
                                           : $urandom_range(int'(CHAR_FIRST), 127);
        if (!glyph_ready(code)) load_glyph(code);
        send_beat(OP_DRAW_CHAR, code, 0);
      end else if (pick < 55) begin
        send_beat(OP_DRAW_CHAR, CHAR_NEWLINE, 0);
      end else if (pick < 65) begin
        code = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(128, 255);
        send_beat(OP_DRAW_CHAR, code, 0);
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0: begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
          end
          1: begin
            x = epw - 8 * font_wbytes() * $urandom_range(0, 2) + $urandom_range(0, 1);
            y = int'(sh_ph) - font_rows() * $urandom_range(0, 2) + $urandom_range(0, 1);
          end
          default: begin
            x = $urandom_range(0, epw);
            y = $urandom_range(0, int'(sh_ph));
          end
        endcase
        x = (x < 0) ? 0 : ((x > 1023) ? 1023 : x);
        y = (y < 0) ? 0 : ((y > 1023) ? 1023 : y);
        send_beat(OP_SET_CURSOR, x, y);
      end else if (pick < 95) begin
        addr = $urandom_range(0, 4095);
        store_byte(addr, $urandom_range(0, 255));
      end else begin
        send_beat(OP_UNUSED, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats on a two-row font
    write_regs(480, 272, 1, 2, 16'hFFFF, 16'h0000, 1);
    store_byte(0, 8'h00);
    store_byte(1, 8'hFF);
    store_byte(190, 8'hA5);
    store_byte(191, 8'h5A);
    store_byte(4095, 8'hFF);
    store_byte(3071, 8'h81);
    send_beat(OP_SET_CURSOR, 0, 0);
    send_beat(OP_DRAW_CHAR, 8'h20, 0);
    send_beat(OP_DRAW_CHAR, 8'h7F, 0);
    send_beat(OP_DRAW_CHAR, CHAR_NEWLINE, 0);
    send_beat(OP_DRAW_CHAR, 8'h00, 0);
    send_beat(OP_DRAW_CHAR, 8'h1F, 0);
    send_beat(OP_DRAW_CHAR, 8'h80, 0);
    send_beat(OP_DRAW_CHAR, 8'hFF, 0);
    send_beat(OP_UNUSED, 4095, 1023);
    send_beat(OP_SET_CURSOR, 476, 0);
    send_beat(OP_DRAW_CHAR, 8'h20, 0);
    send_beat(OP_SET_CURSOR, 1023, 1023);
    send_beat(OP_DRAW_CHAR, 8'h7F, 0);
    send_beat(OP_SET_CURSOR, 0, 270);
    send_beat(OP_DRAW_CHAR, 8'h20, 0);

    write_regs(RST_PANEL_WIDTH, RST_PANEL_HEIGHT, RST_FONT_WBYTES, RST_FONT_HEIGHT,
               $urandom, $urandom, RST_WRAP_CLEARS);
    random_traffic(15);

    // widest panel and font: x saturation, index overflow, y saturation
    write_regs(2047, 2047, 2, 16, $urandom, $urandom, 0);
    if (!glyph_ready(8'h41)) load_glyph(8'h41);
    send_beat(OP_SET_CURSOR, 1008, 1000);
    send_beat(OP_DRAW_CHAR, 8'h41, 0);
    send_beat(OP_DRAW_CHAR, 8'h41, 0);
    repeat (62) send_beat(OP_DRAW_CHAR, CHAR_NEWLINE, 0);
    send_beat(OP_DRAW_CHAR, 8'h41, 0);
    repeat (5) send_beat(OP_DRAW_CHAR, CHAR_NEWLINE, 0);
    send_beat(OP_DRAW_CHAR, 8'h41, 0);
    random_traffic(10);

    write_regs(1, 1, 0, 0, 16'h0000, 16'hFFFF, 1);
    random_traffic(15);

    write_regs(100, 40, 3, 31, $urandom, $urandom, 1);
    random_traffic(10);

    write_regs($urandom_range(8, 1024), $urandom_range(16, 300), $urandom_range(1, 2),
               $urandom_range(1, 16), $urandom, $urandom, $urandom_range(0, 1));
    random_traffic(15);

    write_regs(1024, 1024, 2, 17, $urandom, $urandom, 0);
    random_traffic(10);

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (outstanding != 0) $error("%0d expected pixel beats never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
